// File: sv/int64_div_mod_unit_defines.svh
// assertion macros for the divider
`ifndef INT64_DIV_MOD_UNIT_DEFINES_SVH
`define INT64_DIV_MOD_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define IDM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define IDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define IDM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IDM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/idm_pkg.sv
package idm_pkg;

    localparam int FIELD_W = 64;
    localparam int DATA_WIDTH_DEF = 64;

    typedef enum logic [1:0] {
        MODE_UQUO = 2'd0,
        MODE_UREM = 2'd1,
        MODE_SQUO = 2'd2,
        MODE_SREM = 2'd3
    } t_mode;

    typedef struct packed {
        logic want_rem;
        logic neg_quo;
        logic neg_rem;
        logic dbz;
    } t_ctl;

endpackage

// File: sv/idm_ifs.sv
interface idm_in_if
    import idm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
    logic [1:0]         mode;

    modport source (output valid, dividend, divisor, mode, input ready);
    modport sink (input valid, dividend, divisor, mode, output ready);
endinterface

interface idm_out_if
    import idm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] result;
    logic               divide_by_zero;

    modport source (output valid, result, divide_by_zero, input ready);
    modport sink (input valid, result, divide_by_zero, output ready);
endinterface

// File: sv/idm_cell.sv
module idm_cell
    import idm_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_ctl                  i_ctl,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_quo,
    input  logic [DATA_WIDTH-1:0] i_dvs,
    output logic                  o_valid,
    output t_ctl                  o_ctl,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_quo,
    output logic [DATA_WIDTH-1:0] o_dvs
);

    logic                  r_valid;
    t_ctl                  r_ctl;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_dvs;

    logic [DATA_WIDTH:0]   s_rq;
    logic [DATA_WIDTH:0]   s_diff;
    logic                  s_ge;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_quo;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        s_rq   = {i_rem, i_quo[DATA_WIDTH-1]};
        s_diff = s_rq - {1'b0, i_dvs};
        s_ge   = ~s_diff[DATA_WIDTH];
        n_rem  = s_ge ? s_diff[DATA_WIDTH-1:0] : s_rq[DATA_WIDTH-1:0];
        n_quo  = {i_quo[DATA_WIDTH-2:0], s_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_dvs <= i_dvs;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_dvs   = r_dvs;

endmodule

// File: sv/int64_div_mod_unit.sv
// an accepted item passes through the operand stage, one restoring cell per
// quotient bit and the result stage before its result is valid
// throughput: one item per cycle; the whole chain advances whenever the
// result register is empty or its item is taken
// reset: synchronous active-low i_rst_n clears all stage valid bits
`include "int64_div_mod_unit_defines.svh"

module int64_div_mod_unit
    import idm_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    idm_in_if.sink           i_in,
    idm_out_if.source        o_out
);

    logic                  s_en;

    logic [DATA_WIDTH-1:0] s_a;
    logic [DATA_WIDTH-1:0] s_b;
    logic                  s_signed;
    logic                  s_neg_a;
    logic                  s_neg_b;
    t_ctl                  n_pre_ctl;
    logic [DATA_WIDTH-1:0] n_pre_ma;
    logic [DATA_WIDTH-1:0] n_pre_mb;

    logic                  r_pre_valid;
    t_ctl                  r_pre_ctl;
    logic [DATA_WIDTH-1:0] r_pre_ma;
    logic [DATA_WIDTH-1:0] r_pre_mb;

    logic                  c_valid [0:DATA_WIDTH];
    t_ctl                  c_ctl   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] c_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] c_quo   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] c_dvs   [0:DATA_WIDTH];

    t_ctl                  s_last_ctl;
    logic [DATA_WIDTH-1:0] s_res;
    logic [FIELD_W-1:0]    n_result;

    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_result;
    logic                  r_dbz;
    logic                  r_out_quo_dbz;

    assign s_en = ~r_out_valid | o_out.ready;
    assign i_in.ready = s_en;

    // operand stage: magnitudes and sign handling
    always_comb begin
        s_a      = i_in.dividend[DATA_WIDTH-1:0];
        s_b      = i_in.divisor[DATA_WIDTH-1:0];
        s_signed = (i_in.mode == MODE_SQUO) || (i_in.mode == MODE_SREM);
        s_neg_a  = s_signed & s_a[DATA_WIDTH-1];
        s_neg_b  = s_signed & s_b[DATA_WIDTH-1];
        n_pre_ctl.want_rem = (i_in.mode == MODE_UREM) || (i_in.mode == MODE_SREM);
        n_pre_ctl.dbz      = (s_b == '0);
        n_pre_ctl.neg_rem  = s_neg_a;
        n_pre_ctl.neg_quo  = (s_neg_a ^ s_neg_b) & ~n_pre_ctl.dbz;
        n_pre_ma = s_neg_a ? (-s_a) : s_a;
        n_pre_mb = s_neg_b ? (-s_b) : s_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (s_en) begin
            r_pre_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_pre_ctl <= n_pre_ctl;
            r_pre_ma  <= n_pre_ma;
            r_pre_mb  <= n_pre_mb;
        end
    end

    assign c_valid[0] = r_pre_valid;
    assign c_ctl[0]   = r_pre_ctl;
    assign c_rem[0]   = '0;
    assign c_quo[0]   = r_pre_ma;
    assign c_dvs[0]   = r_pre_mb;

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        idm_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_valid (c_valid[g]),
            .i_ctl   (c_ctl[g]),
            .i_rem   (c_rem[g]),
            .i_quo   (c_quo[g]),
            .i_dvs   (c_dvs[g]),
            .o_valid (c_valid[g+1]),
            .o_ctl   (c_ctl[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_quo   (c_quo[g+1]),
            .o_dvs   (c_dvs[g+1])
        );
    end

    // result stage: restore signs and pick quotient or remainder
    always_comb begin
        s_last_ctl = c_ctl[DATA_WIDTH];
        if (s_last_ctl.want_rem) begin
            s_res = s_last_ctl.neg_rem ? (-c_rem[DATA_WIDTH]) : c_rem[DATA_WIDTH];
        end else begin
            s_res = s_last_ctl.neg_quo ? (-c_quo[DATA_WIDTH]) : c_quo[DATA_WIDTH];
        end
        n_result = FIELD_W'(s_res);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_en) begin
            r_out_valid <= c_valid[DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_result      <= n_result;
            r_dbz         <= s_last_ctl.dbz;
            r_out_quo_dbz <= s_last_ctl.dbz & ~s_last_ctl.want_rem;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result         = r_result;
    assign o_out.divide_by_zero = r_dbz;

    `IDM_ASSERT_NEXT(a_chain_advance, i_clk, i_rst_n, s_en && r_pre_valid, c_valid[1])
    `IDM_ASSERT_IMPL(a_rem_below_dvs, i_clk, i_rst_n,
                     c_valid[DATA_WIDTH] && !s_last_ctl.dbz,
                     c_rem[DATA_WIDTH] < c_dvs[DATA_WIDTH])
    `IDM_ASSERT_IMPL(a_dbz_quo_ones, i_clk, i_rst_n, r_out_valid && r_out_quo_dbz,
                     r_result == FIELD_W'({DATA_WIDTH{1'b1}}))

endmodule
